// File: rtl/hsvled_pkg.sv
// ----------------------------------------------------------------------------
// hsvled_pkg
// Shared constants and helpers for the hsv pixel to led word unit.
// ----------------------------------------------------------------------------
`default_nettype none

package hsvled_pkg;

    localparam int unsigned MAX_LEDS     = 1024;
    localparam int unsigned BITS_PER_LED = 24;

    localparam int unsigned INDEX_W = 10;
    localparam int unsigned COLOR_W = 8;
    localparam int unsigned COUNT_W = 11;
    localparam int unsigned OFFS_W  = 10;
    localparam int unsigned ADDR_W  = 15;
    localparam int unsigned WORD_W  = 24;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 11;

    localparam logic [COLOR_W-1:0] FULL_LEVEL      = 8'd255;
    localparam logic [COLOR_W-1:0] HUE_REGION_SPAN = 8'd43;

    localparam logic [COUNT_W-1:0] LED_COUNT_RESET   = 11'd1024;
    localparam logic [OFFS_W-1:0]  SLOT_OFFSET_RESET = 10'd0;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_START_OFFSET = 2'd1;

    // hue regions
    localparam logic [2:0] REGION_0 = 3'd0;
    localparam logic [2:0] REGION_1 = 3'd1;
    localparam logic [2:0] REGION_2 = 3'd2;
    localparam logic [2:0] REGION_3 = 3'd3;
    localparam logic [2:0] REGION_4 = 3'd4;
    localparam logic [2:0] REGION_5 = 3'd5;

    // hue / 43 by threshold compare
    function automatic logic [2:0] hue_region(input logic [COLOR_W-1:0] hue);
        logic [2:0] r;
        r = REGION_0;
        if (hue >= 8'(2 * 43)) r = REGION_2;
        else if (hue >= HUE_REGION_SPAN) r = REGION_1;
        if (hue >= 8'(5 * 43)) r = REGION_5;
        else if (hue >= 8'(4 * 43)) r = REGION_4;
        else if (hue >= 8'(3 * 43)) r = REGION_3;
        return r;
    endfunction

    // region * 43
    function automatic logic [COLOR_W-1:0] region_base(input logic [2:0] region);
        logic [COLOR_W-1:0] b;
        case (region)
            REGION_0: b = 8'd0;
            REGION_1: b = 8'(1 * 43);
            REGION_2: b = 8'(2 * 43);
            REGION_3: b = 8'(3 * 43);
            REGION_4: b = 8'(4 * 43);
            default:  b = 8'(5 * 43);
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: rtl/hsv_pixel_to_led_word_unit.sv
// ----------------------------------------------------------------------------
// hsv_pixel_to_led_word_unit
// Converts an hsv pixel to rgb, packs the grb led word and its slot address.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_* carries an led index with hue, saturation and
//   brightness; result channel m_* carries the index, red, green, blue, the
//   24-bit grb word (green high, sent msb first) and the first bit slot
//   address (offset + index * 24). Both use valid/ready.
//   An item whose index is at or above led_count is accepted and dropped.
//   Configuration (led_count, slot_start_offset) is written through
//   cfg_wr_en / cfg_index / cfg_wdata; the user must do so only while no item
//   is in flight, which the block does not enforce. A result is presented on
//   m_valid after passing four register stages (s1, s2, s3, output), the first
//   loaded at the accepting edge. Throughput: one item per clock while m_ready
//   is high; the two multiply stages set the depth. When m_ready is low the
//   stages fill up and s_ready falls once all four hold items; nothing is lost
//   or repeated. Reset (aresetn low, synchronous) empties the pipeline and
//   restores led_count to 1024 and slot_start_offset to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_pixel_to_led_word_unit
    import hsvled_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [INDEX_W-1:0]    s_led_index,
    input  wire logic [COLOR_W-1:0]    s_hue,
    input  wire logic [COLOR_W-1:0]    s_saturation,
    input  wire logic [COLOR_W-1:0]    s_brightness,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [INDEX_W-1:0]         m_out_index,
    output logic [COLOR_W-1:0]         m_red,
    output logic [COLOR_W-1:0]         m_green,
    output logic [COLOR_W-1:0]         m_blue,
    output logic [WORD_W-1:0]          m_grb_word,
    output logic [ADDR_W-1:0]          m_slot_address
);

    // configuration
    logic [COUNT_W-1:0] led_count_reg;
    logic [OFFS_W-1:0]  slot_offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_count_reg   <= LED_COUNT_RESET;
            slot_offset_reg <= SLOT_OFFSET_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_LED_COUNT:         led_count_reg   <= cfg_wdata;
                REG_SLOT_START_OFFSET: slot_offset_reg <= cfg_wdata[OFFS_W-1:0];
                default: ;
            endcase
        end
    end

    // stage control
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s2_ready, s3_ready, out_ready;

    assign out_ready = !out_valid_reg || m_ready;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s_ready   = !s1_valid_reg || s2_ready;

    logic in_range;
    assign in_range = ({1'b0, s_led_index} < led_count_reg)
                   && (32'(s_led_index) < 32'(MAX_LEDS));

    // stage 1: region, remainder, slot address
    logic [2:0]         region_c;
    logic [COLOR_W-1:0] hue_off_c;
    logic [COLOR_W-1:0] rem_c;
    logic [ADDR_W-1:0]  addr_c;

    assign region_c  = hue_region(s_hue);
    assign hue_off_c = s_hue - region_base(region_c);
    assign rem_c     = 8'({hue_off_c, 2'b00} + {1'b0, hue_off_c, 1'b0});
    assign addr_c    = ADDR_W'({s_led_index, 4'b0000})
                     + ADDR_W'({s_led_index, 3'b000})
                     + ADDR_W'(slot_offset_reg);

    logic [INDEX_W-1:0] s1_index_reg;
    logic [2:0]         s1_region_reg;
    logic [COLOR_W-1:0] s1_rem_reg, s1_sat_reg, s1_val_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;

    // stage 2: first-level products
    logic [15:0] p_prod_c, sq_prod_c, st_prod_c;
    assign p_prod_c  = 16'(s1_val_reg) * 16'(FULL_LEVEL - s1_sat_reg);
    assign sq_prod_c = 16'(s1_sat_reg) * 16'(s1_rem_reg);
    assign st_prod_c = 16'(s1_sat_reg) * 16'(FULL_LEVEL - s1_rem_reg);

    logic [INDEX_W-1:0] s2_index_reg;
    logic [2:0]         s2_region_reg;
    logic               s2_grey_reg;
    logic [COLOR_W-1:0] s2_val_reg, s2_p_reg, s2_sq_reg, s2_st_reg;
    logic [ADDR_W-1:0]  s2_addr_reg;

    // stage 3: q and t
    logic [15:0] q_prod_c, t_prod_c;
    assign q_prod_c = 16'(s2_val_reg) * 16'(FULL_LEVEL - s2_sq_reg);
    assign t_prod_c = 16'(s2_val_reg) * 16'(FULL_LEVEL - s2_st_reg);

    logic [INDEX_W-1:0] s3_index_reg;
    logic [2:0]         s3_region_reg;
    logic               s3_grey_reg;
    logic [COLOR_W-1:0] s3_val_reg, s3_p_reg, s3_q_reg, s3_t_reg;
    logic [ADDR_W-1:0]  s3_addr_reg;

    // output stage: channel select
    logic [COLOR_W-1:0] red_next, green_next, blue_next;

    always_comb begin
        red_next   = s3_val_reg;
        green_next = s3_val_reg;
        blue_next  = s3_val_reg;
        if (!s3_grey_reg) begin
            case (s3_region_reg)
                REGION_0: begin
                    red_next = s3_val_reg; green_next = s3_t_reg;   blue_next = s3_p_reg;
                end
                REGION_1: begin
                    red_next = s3_q_reg;   green_next = s3_val_reg; blue_next = s3_p_reg;
                end
                REGION_2: begin
                    red_next = s3_p_reg;   green_next = s3_val_reg; blue_next = s3_t_reg;
                end
                REGION_3: begin
                    red_next = s3_p_reg;   green_next = s3_q_reg;   blue_next = s3_val_reg;
                end
                REGION_4: begin
                    red_next = s3_t_reg;   green_next = s3_p_reg;   blue_next = s3_val_reg;
                end
                default: begin
                    red_next = s3_val_reg; green_next = s3_p_reg;   blue_next = s3_q_reg;
                end
            endcase
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            // out-of-range items are taken but never become valid
            if (s_ready)   s1_valid_reg  <= s_valid && in_range;
            if (s2_ready)  s2_valid_reg  <= s1_valid_reg;
            if (s3_ready)  s3_valid_reg  <= s2_valid_reg;
            if (out_ready) out_valid_reg <= s3_valid_reg;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_ready) begin
            s1_index_reg  <= s_led_index;
            s1_region_reg <= region_c;
            s1_rem_reg    <= rem_c;
            s1_sat_reg    <= s_saturation;
            s1_val_reg    <= s_brightness;
            s1_addr_reg   <= addr_c;
        end
        if (s2_ready) begin
            s2_index_reg  <= s1_index_reg;
            s2_region_reg <= s1_region_reg;
            s2_grey_reg   <= (s1_sat_reg == '0);
            s2_val_reg    <= s1_val_reg;
            s2_p_reg      <= p_prod_c[15:8];
            s2_sq_reg     <= sq_prod_c[15:8];
            s2_st_reg     <= st_prod_c[15:8];
            s2_addr_reg   <= s1_addr_reg;
        end
        if (s3_ready) begin
            s3_index_reg  <= s2_index_reg;
            s3_region_reg <= s2_region_reg;
            s3_grey_reg   <= s2_grey_reg;
            s3_val_reg    <= s2_val_reg;
            s3_p_reg      <= s2_p_reg;
            s3_q_reg      <= q_prod_c[15:8];
            s3_t_reg      <= t_prod_c[15:8];
            s3_addr_reg   <= s2_addr_reg;
        end
        if (out_ready) begin
            m_out_index    <= s3_index_reg;
            m_red          <= red_next;
            m_green        <= green_next;
            m_blue         <= blue_next;
            m_grb_word     <= {green_next, red_next, blue_next};
            m_slot_address <= s3_addr_reg;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

`default_nettype wire
